// ===== hdl/tte_pkg.sv =====
// Shared types, constants and the color palette for the text terminal escape engine.
// Depends on nothing; used by text_terminal_escape_engine_unit.
`timescale 1ns / 1ps
`default_nettype none

package tte_pkg;

	localparam int unsigned MAX_COLS = 128;
	localparam int unsigned MAX_ROWS = 64;

	localparam int unsigned COLS_W = 8;
	localparam int unsigned ROWS_W = 7;
	localparam int unsigned ROW_W  = 6;
	localparam int unsigned COL_W  = 7;
	localparam int unsigned ORG_W  = 12;
	localparam int unsigned PIX_W  = 13;
	localparam int unsigned RGB_W  = 24;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd3;

	localparam logic [COLS_W-1:0] COLS_RESET = 8'd80;
	localparam logic [ROWS_W-1:0] ROWS_RESET = 7'd25;

	localparam logic [7:0] CH_ESC    = 8'h1B;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_M      = 8'h6D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam logic [RGB_W-1:0] WHITE = 24'hFFFFFF;
	localparam logic [RGB_W-1:0] BLACK = 24'h000000;

	localparam logic [7:0] SGR_RESET   = 8'd0;
	localparam logic [7:0] SGR_FG_LOW  = 8'd30;
	localparam logic [7:0] SGR_FG_HIGH = 8'd37;
	localparam logic [7:0] SGR_BG_LOW  = 8'd40;
	localparam logic [7:0] SGR_BG_HIGH = 8'd47;
	localparam logic [7:0] PARAM_MAX   = 8'd255;

	typedef enum logic [1:0] {
		OP_DRAW   = 2'd0,
		OP_ERASE  = 2'd1,
		OP_SCROLL = 2'd2
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [ROW_W-1:0] store_row;
		logic [COL_W-1:0] store_col;
		logic [PIX_W-1:0] pixel_x;
		logic [PIX_W-1:0] pixel_y;
		logic [7:0]       char_code;
		logic [RGB_W-1:0] fg_colour;
		logic [RGB_W-1:0] bg_colour;
		logic [ROW_W-1:0] top_row;
		logic             last;
	} result_t;

	function automatic logic [RGB_W-1:0] palette(input logic [2:0] idx);
		logic [RGB_W-1:0] c;
		case (idx)
			3'd0: c = 24'h000000;
			3'd1: c = 24'hFF0000;
			3'd2: c = 24'h00FF00;
			3'd3: c = 24'hF08000;
			3'd4: c = 24'h0000FF;
			3'd5: c = 24'hFF00FF;
			3'd6: c = 24'h008080;
			default: c = 24'h808080;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/text_terminal_escape_engine_unit.sv =====
// Top level of the text terminal escape engine: byte input register, command decode and output pair.
// Depends on tte_pkg for types, constants and the palette.
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Handshake           | Payload
// byte     | in        | byte_valid/stall    | byte_in
// result   | out       | result_valid/stall  | op .. last
// cfg      | in        | cfg_valid/ready     | cfg_index, cfg_data
//
// A byte is held in the input register and decoded there; its results are registered in the
// output pair. One byte per cycle is sustained while each byte gives at most one result and the
// output is not stalled; a byte with two results holds the pair until both are taken. After reset
// all state but the input byte and output slots holds its initial value. A write to rows reduces
// the ring top by repeated subtraction while bytes wait. Output stall backs up into byte_stall.
module text_terminal_escape_engine_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              byte_valid,
	output logic                                   byte_stall,
	input  wire logic [7:0]                        byte_in,
	output logic                                   result_valid,
	input  wire logic                              result_stall,
	output logic [1:0]                             op,
	output logic [tte_pkg::ROW_W-1:0]              store_row,
	output logic [tte_pkg::COL_W-1:0]              store_col,
	output logic [tte_pkg::PIX_W-1:0]              pixel_x,
	output logic [tte_pkg::PIX_W-1:0]              pixel_y,
	output logic [7:0]                             char_code,
	output logic [tte_pkg::RGB_W-1:0]              fg_colour,
	output logic [tte_pkg::RGB_W-1:0]              bg_colour,
	output logic [tte_pkg::ROW_W-1:0]              top_row,
	output logic                                   last,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [tte_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [tte_pkg::ORG_W-1:0]         cfg_data
);

	logic [tte_pkg::COLS_W-1:0] columns_q;
	logic [tte_pkg::ROWS_W-1:0] rows_q;
	logic [tte_pkg::ORG_W-1:0]  origin_x_q;
	logic [tte_pkg::ORG_W-1:0]  origin_y_q;

	logic [tte_pkg::ROW_W-1:0]  cursor_row_q;
	logic [tte_pkg::COL_W-1:0]  cursor_col_q;
	logic                       in_escape_q;
	logic [7:0]                 param_value_q;
	logic                       param_open_q;
	logic                       param_stopped_q;
	logic [tte_pkg::RGB_W-1:0]  fore_q;
	logic [tte_pkg::RGB_W-1:0]  back_q;
	logic [tte_pkg::ROW_W-1:0]  ring_top_q;

	logic                       valid_s1;
	logic [7:0]                 byte_s1;

	tte_pkg::result_t           slot0_q;
	tte_pkg::result_t           slot1_q;
	logic [1:0]                 count_q;

	logic [tte_pkg::COLS_W-1:0] cols_c;
	logic [tte_pkg::ROWS_W-1:0] rows_c;
	logic [tte_pkg::COLS_W-1:0] col_c;
	logic [tte_pkg::ROWS_W-1:0] row_c;
	logic                       fix_need;
	logic                       pop;
	logic                       out_free;
	logic                       advance;

	logic [tte_pkg::COLS_W-1:0] col_n;
	logic [tte_pkg::ROWS_W-1:0] row_n;
	logic [tte_pkg::ROW_W-1:0]  top_n;
	logic                       esc_n;
	logic [7:0]                 pv_n;
	logic                       popen_n;
	logic                       pstop_n;
	logic [tte_pkg::RGB_W-1:0]  fore_n;
	logic [tte_pkg::RGB_W-1:0]  back_n;
	tte_pkg::result_t           r0;
	tte_pkg::result_t           r1;
	tte_pkg::result_t           scroll_r;
	logic [1:0]                 n_res;

	logic [tte_pkg::ROWS_W-1:0] srow_sum;
	logic [tte_pkg::ROW_W-1:0]  srow;
	logic [tte_pkg::COLS_W-1:0] col_use;
	logic [tte_pkg::COLS_W-1:0] tab_col;
	logic [11:0]                pv_mul;
	logic [7:0]                 sgr_code;
	logic                       sgr_apply;
	logic [7:0]                 sgr_diff;
	logic [tte_pkg::ROW_W-1:0]  top_inc;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (columns_q == '0) begin
			cols_c = tte_pkg::COLS_W'(1);
		end else if (columns_q > tte_pkg::COLS_W'(tte_pkg::MAX_COLS)) begin
			cols_c = tte_pkg::COLS_W'(tte_pkg::MAX_COLS);
		end else begin
			cols_c = columns_q;
		end
		if (rows_q == '0) begin
			rows_c = tte_pkg::ROWS_W'(1);
		end else if (rows_q > tte_pkg::ROWS_W'(tte_pkg::MAX_ROWS)) begin
			rows_c = tte_pkg::ROWS_W'(tte_pkg::MAX_ROWS);
		end else begin
			rows_c = rows_q;
		end
	end

	assign col_c = ({1'b0, cursor_col_q} >= cols_c) ? cols_c - 1'b1 : {1'b0, cursor_col_q};
	assign row_c = ({1'b0, cursor_row_q} >= rows_c) ? rows_c - 1'b1 : {1'b0, cursor_row_q};
	assign fix_need = {1'b0, ring_top_q} >= rows_c;

	assign result_valid = (count_q != 2'd0);
	assign pop = result_valid && !result_stall;
	assign out_free = (count_q == 2'd0) || (count_q == 2'd1 && pop);
	assign advance = valid_s1 && out_free && !fix_need;
	assign byte_stall = valid_s1 && !advance;

	always_comb begin
		col_n = col_c;
		row_n = row_c;
		top_n = ring_top_q;
		esc_n = in_escape_q;
		pv_n = param_value_q;
		popen_n = param_open_q;
		pstop_n = param_stopped_q;
		fore_n = fore_q;
		back_n = back_q;
		r0 = '0;
		r1 = '0;
		scroll_r = '0;
		n_res = 2'd0;
		col_use = col_c;
		tab_col = '0;
		pv_mul = '0;
		sgr_code = param_value_q;
		sgr_apply = 1'b0;
		sgr_diff = '0;
		top_inc = '0;

		srow_sum = {1'b0, ring_top_q} + row_c;
		srow = (srow_sum >= rows_c) ? tte_pkg::ROW_W'(srow_sum - rows_c)
			: tte_pkg::ROW_W'(srow_sum);

		if (in_escape_q) begin
			if (byte_s1 == tte_pkg::CH_M) begin
				sgr_apply = param_open_q;
				esc_n = 1'b0;
				popen_n = 1'b0;
			end else if (byte_s1 == tte_pkg::CH_LBRACK || byte_s1 == tte_pkg::CH_SEMI) begin
				sgr_apply = param_open_q;
				popen_n = 1'b1;
				pstop_n = 1'b0;
				pv_n = '0;
			end else if (byte_s1 >= tte_pkg::CH_ZERO && byte_s1 <= tte_pkg::CH_NINE) begin
				pv_mul = ({4'b0, param_value_q} << 3) + ({4'b0, param_value_q} << 1)
					+ {8'b0, byte_s1[3:0]};
				if (param_open_q && !param_stopped_q) begin
					pv_n = (pv_mul > 12'(tte_pkg::PARAM_MAX)) ? tte_pkg::PARAM_MAX
						: pv_mul[7:0];
				end
			end else begin
				pstop_n = 1'b1;
			end
			if (sgr_apply) begin
				if (sgr_code == tte_pkg::SGR_RESET) begin
					fore_n = tte_pkg::WHITE;
					back_n = tte_pkg::BLACK;
				end else if (sgr_code >= tte_pkg::SGR_FG_LOW
					&& sgr_code <= tte_pkg::SGR_FG_HIGH) begin
					sgr_diff = sgr_code - tte_pkg::SGR_FG_LOW;
					fore_n = tte_pkg::palette(sgr_diff[2:0]);
				end else if (sgr_code >= tte_pkg::SGR_BG_LOW
					&& sgr_code <= tte_pkg::SGR_BG_HIGH) begin
					sgr_diff = sgr_code - tte_pkg::SGR_BG_LOW;
					back_n = tte_pkg::palette(sgr_diff[2:0]);
				end
			end
		end else begin
			unique case (byte_s1)
				tte_pkg::CH_ESC: begin
					esc_n = 1'b1;
					popen_n = 1'b0;
					pstop_n = 1'b0;
					pv_n = '0;
				end
				tte_pkg::CH_BS: begin
					col_use = (col_c != '0) ? col_c - 1'b1 : col_c;
					col_n = col_use;
					r0.op = tte_pkg::OP_ERASE;
					r0.char_code = tte_pkg::CH_SPACE;
					n_res = 2'd1;
				end
				tte_pkg::CH_TAB: begin
					tab_col = (col_c + tte_pkg::COLS_W'(8)) & ~tte_pkg::COLS_W'(7);
					if (tab_col >= cols_c) begin
						col_n = '0;
						row_n = row_c + 1'b1;
					end else begin
						col_n = tab_col;
					end
				end
				tte_pkg::CH_LF: begin
					col_n = '0;
					row_n = row_c + 1'b1;
				end
				tte_pkg::CH_CR: begin
					col_n = '0;
				end
				default: begin
					r0.op = tte_pkg::OP_DRAW;
					r0.char_code = byte_s1;
					n_res = 2'd1;
					if (col_c + 1'b1 >= cols_c) begin
						col_n = '0;
						row_n = row_c + 1'b1;
					end else begin
						col_n = col_c + 1'b1;
					end
				end
			endcase
			r0.store_row = srow;
			r0.store_col = col_use[tte_pkg::COL_W-1:0];
			r0.pixel_x = {1'b0, origin_x_q}
				+ {3'b0, col_use[tte_pkg::COL_W-1:0], 3'b0};
			r0.pixel_y = {1'b0, origin_y_q}
				+ {3'b0, row_c[tte_pkg::ROW_W-1:0], 4'b0};
			r0.fg_colour = fore_q;
			r0.bg_colour = back_q;
			r0.top_row = ring_top_q;

			if (row_n >= rows_c) begin
				top_inc = ring_top_q + 1'b1;
				top_n = ({1'b0, top_inc} == rows_c) ? '0 : top_inc;
				row_n = rows_c - 1'b1;
				scroll_r.op = tte_pkg::OP_SCROLL;
				scroll_r.store_row = ring_top_q;
				scroll_r.store_col = '0;
				scroll_r.pixel_x = {1'b0, origin_x_q};
				scroll_r.pixel_y = {1'b0, origin_y_q};
				scroll_r.char_code = tte_pkg::CH_SPACE;
				scroll_r.fg_colour = fore_q;
				scroll_r.bg_colour = back_q;
				scroll_r.top_row = top_n;
				if (n_res == 2'd0) begin
					r0 = scroll_r;
					n_res = 2'd1;
				end else begin
					r1 = scroll_r;
					n_res = 2'd2;
				end
			end
			if (n_res == 2'd1) begin
				r0.last = 1'b1;
			end else if (n_res == 2'd2) begin
				r1.last = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= tte_pkg::COLS_RESET;
			rows_q <= tte_pkg::ROWS_RESET;
			origin_x_q <= '0;
			origin_y_q <= '0;
			cursor_row_q <= '0;
			cursor_col_q <= '0;
			in_escape_q <= 1'b0;
			param_value_q <= '0;
			param_open_q <= 1'b0;
			param_stopped_q <= 1'b0;
			fore_q <= tte_pkg::WHITE;
			back_q <= tte_pkg::BLACK;
			ring_top_q <= '0;
			valid_s1 <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					tte_pkg::REG_COLUMNS:  columns_q <= cfg_data[tte_pkg::COLS_W-1:0];
					tte_pkg::REG_ROWS:     rows_q <= cfg_data[tte_pkg::ROWS_W-1:0];
					tte_pkg::REG_ORIGIN_X: origin_x_q <= cfg_data;
					default:               origin_y_q <= cfg_data;
				endcase
			end

			if (fix_need) begin
				ring_top_q <= ring_top_q - tte_pkg::ROW_W'(rows_c);
			end else if (advance) begin
				ring_top_q <= top_n;
			end

			if (advance) begin
				cursor_col_q <= col_n[tte_pkg::COL_W-1:0];
				cursor_row_q <= row_n[tte_pkg::ROW_W-1:0];
				in_escape_q <= esc_n;
				param_value_q <= pv_n;
				param_open_q <= popen_n;
				param_stopped_q <= pstop_n;
				fore_q <= fore_n;
				back_q <= back_n;
			end

			if (byte_valid && !byte_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end

			if (advance) begin
				count_q <= n_res;
			end else if (pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= byte_in;
		end
		if (advance) begin
			slot0_q <= r0;
			slot1_q <= r1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

	assign op        = slot0_q.op;
	assign store_row = slot0_q.store_row;
	assign store_col = slot0_q.store_col;
	assign pixel_x   = slot0_q.pixel_x;
	assign pixel_y   = slot0_q.pixel_y;
	assign char_code = slot0_q.char_code;
	assign fg_colour = slot0_q.fg_colour;
	assign bg_colour = slot0_q.bg_colour;
	assign top_row   = slot0_q.top_row;
	assign last      = slot0_q.last;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for text_terminal_escape_engine_unit: directed and random byte streams
// drive a behavioral model of the cursor, row ring and SGR color parser, and every result transfer
// is checked field by field. Depends on tte_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module testbench;

	localparam int QUIET_LIMIT = 4000;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_COIN,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_pattern_t;

	class terminal_shadow_t;
		logic [tte_pkg::COLS_W-1:0] columns_reg;
		logic [tte_pkg::ROWS_W-1:0] rows_reg;
		logic [tte_pkg::ORG_W-1:0]  org_x;
		logic [tte_pkg::ORG_W-1:0]  org_y;
		logic [tte_pkg::ROW_W-1:0]  cur_row;
		logic [tte_pkg::COL_W-1:0]  cur_col;
		logic [tte_pkg::ROW_W-1:0]  ring_head;
		bit                         esc_active;
		bit                         num_open;
		bit                         num_done;
		logic [7:0]                 num_value;
		logic [tte_pkg::RGB_W-1:0]  fg;
		logic [tte_pkg::RGB_W-1:0]  bg;
		tte_pkg::result_t           pending_cmds[$];
		int                         mismatch_count;
		int                         checked_count;

		function new();
			columns_reg = tte_pkg::COLS_RESET;
			rows_reg = tte_pkg::ROWS_RESET;
			org_x = '0;
			org_y = '0;
			cur_row = '0;
			cur_col = '0;
			ring_head = '0;
			esc_active = 0;
			num_open = 0;
			num_done = 0;
			num_value = '0;
			fg = tte_pkg::WHITE;
			bg = tte_pkg::BLACK;
			mismatch_count = 0;
			checked_count = 0;
		endfunction

		function void set_reg(logic [tte_pkg::CFG_IDX_W-1:0] idx,
				logic [tte_pkg::ORG_W-1:0] data);
			case (idx)
				tte_pkg::REG_COLUMNS:  columns_reg = data[tte_pkg::COLS_W-1:0];
				tte_pkg::REG_ROWS:     rows_reg = data[tte_pkg::ROWS_W-1:0];
				tte_pkg::REG_ORIGIN_X: org_x = data;
				tte_pkg::REG_ORIGIN_Y: org_y = data;
				default: ;
			endcase
		endfunction

		function logic [tte_pkg::RGB_W-1:0] sgr_color(int unsigned idx);
			case (idx)
				0: return 24'h000000;
				1: return 24'hFF0000;
				2: return 24'h00FF00;
				3: return 24'hF08000;
				4: return 24'h0000FF;
				5: return 24'hFF00FF;
				6: return 24'h008080;
				default: return 24'h808080;
			endcase
		endfunction

		function void apply_sgr(int unsigned code);
			if (code == tte_pkg::SGR_RESET) begin
				fg = tte_pkg::WHITE;
				bg = tte_pkg::BLACK;
			end else if (code >= tte_pkg::SGR_FG_LOW && code <= tte_pkg::SGR_FG_HIGH) begin
				fg = sgr_color(code - tte_pkg::SGR_FG_LOW);
			end else if (code >= tte_pkg::SGR_BG_LOW && code <= tte_pkg::SGR_BG_HIGH) begin
				bg = sgr_color(code - tte_pkg::SGR_BG_LOW);
			end
		endfunction

		function tte_pkg::result_t make_cmd(tte_pkg::op_t kind, int unsigned srow,
				int unsigned col, int unsigned px, int unsigned py, logic [7:0] ch,
				int unsigned top);
			tte_pkg::result_t c;
			c.op = kind;
			c.store_row = srow[tte_pkg::ROW_W-1:0];
			c.store_col = col[tte_pkg::COL_W-1:0];
			c.pixel_x = px[tte_pkg::PIX_W-1:0];
			c.pixel_y = py[tte_pkg::PIX_W-1:0];
			c.char_code = ch;
			c.fg_colour = fg;
			c.bg_colour = bg;
			c.top_row = top[tte_pkg::ROW_W-1:0];
			c.last = 1'b0;
			return c;
		endfunction

		function void absorb_byte(logic [7:0] b);
			int unsigned cols, rows, row, col, top, srow, code;
			tte_pkg::result_t cmds[$];
			cols = columns_reg;
			rows = rows_reg;
			if (cols < 1) cols = 1;
			if (cols > tte_pkg::MAX_COLS) cols = tte_pkg::MAX_COLS;
			if (rows < 1) rows = 1;
			if (rows > tte_pkg::MAX_ROWS) rows = tte_pkg::MAX_ROWS;
			col = cur_col;
			row = cur_row;
			top = ring_head;
			if (col >= cols) col = cols - 1;
			if (row >= rows) row = rows - 1;
			top = top % rows;

			if (esc_active) begin
				if (b == tte_pkg::CH_M) begin
					if (num_open) apply_sgr(num_value);
					esc_active = 0;
					num_open = 0;
				end else if (b == tte_pkg::CH_LBRACK || b == tte_pkg::CH_SEMI) begin
					if (num_open) apply_sgr(num_value);
					num_open = 1;
					num_done = 0;
					num_value = '0;
				end else if (b >= tte_pkg::CH_ZERO && b <= tte_pkg::CH_NINE) begin
					if (num_open && !num_done) begin
						code = num_value * 10 + (b - tte_pkg::CH_ZERO);
						num_value = (code > tte_pkg::PARAM_MAX) ? tte_pkg::PARAM_MAX
							: code[7:0];
					end
				end else begin
					num_done = 1;
				end
			end else begin
				srow = top + row;
				if (srow >= rows) srow -= rows;
				case (b)
					tte_pkg::CH_ESC: begin
						esc_active = 1;
						num_open = 0;
						num_done = 0;
						num_value = '0;
					end
					tte_pkg::CH_BS: begin
						if (col != 0) col--;
						cmds.push_back(make_cmd(tte_pkg::OP_ERASE, srow, col, org_x + col * 8,
							org_y + row * 16, tte_pkg::CH_SPACE, top));
					end
					tte_pkg::CH_TAB: begin
						col = (col + 8) / 8 * 8;
						if (col >= cols) begin
							col = 0;
							row++;
						end
					end
					tte_pkg::CH_LF: begin
						col = 0;
						row++;
					end
					tte_pkg::CH_CR: col = 0;
					default: begin
						cmds.push_back(make_cmd(tte_pkg::OP_DRAW, srow, col, org_x + col * 8,
							org_y + row * 16, b, top));
						col++;
						if (col >= cols) begin
							col = 0;
							row++;
						end
					end
				endcase
				if (row >= rows) begin
					cmds.push_back(make_cmd(tte_pkg::OP_SCROLL, top, 0, org_x, org_y,
						tte_pkg::CH_SPACE, (top + 1) % rows));
					top = (top + 1) % rows;
					row = rows - 1;
				end
				if (cmds.size() > 0) cmds[cmds.size() - 1].last = 1'b1;
				foreach (cmds[i]) pending_cmds.push_back(cmds[i]);
			end
			cur_col = col[tte_pkg::COL_W-1:0];
			cur_row = row[tte_pkg::ROW_W-1:0];
			ring_head = top[tte_pkg::ROW_W-1:0];
		endfunction

		task report(string msg);
			mismatch_count++;
			$display("MISMATCH at result %0d: %s", checked_count, msg);
		endtask

		task compare_field(string name, logic [31:0] got, logic [31:0] want);
			if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
		endtask

		task check_command(tte_pkg::result_t got);
			tte_pkg::result_t want;
			checked_count++;
			if (pending_cmds.size() == 0) begin
				report($sformatf("unexpected transfer op=%0d row=%0d col=%0d",
					got.op, got.store_row, got.store_col));
				return;
			end
			want = pending_cmds.pop_front();
			compare_field("op", got.op, want.op);
			compare_field("store_row", got.store_row, want.store_row);
			compare_field("store_col", got.store_col, want.store_col);
			compare_field("pixel_x", got.pixel_x, want.pixel_x);
			compare_field("pixel_y", got.pixel_y, want.pixel_y);
			compare_field("char_code", got.char_code, want.char_code);
			compare_field("fg_colour", got.fg_colour, want.fg_colour);
			compare_field("bg_colour", got.bg_colour, want.bg_colour);
			compare_field("top_row", got.top_row, want.top_row);
			compare_field("last", got.last, want.last);
		endtask

		task close_out();
			while (pending_cmds.size() > 0) begin
				report($sformatf("missing transfer op=%0d row=%0d col=%0d",
					pending_cmds[0].op, pending_cmds[0].store_row, pending_cmds[0].store_col));
				void'(pending_cmds.pop_front());
			end
		endtask
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          byte_valid = 1'b0;
	logic                          byte_stall;
	logic [7:0]                    byte_in = '0;
	logic                          result_valid;
	logic                          result_stall = 1'b0;
	logic [1:0]                    op;
	logic [tte_pkg::ROW_W-1:0]     store_row;
	logic [tte_pkg::COL_W-1:0]     store_col;
	logic [tte_pkg::PIX_W-1:0]     pixel_x;
	logic [tte_pkg::PIX_W-1:0]     pixel_y;
	logic [7:0]                    char_code;
	logic [tte_pkg::RGB_W-1:0]     fg_colour;
	logic [tte_pkg::RGB_W-1:0]     bg_colour;
	logic [tte_pkg::ROW_W-1:0]     top_row;
	logic                          last;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [tte_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [tte_pkg::ORG_W-1:0]     cfg_data = '0;

	terminal_shadow_t shadow;
	int               burst_left = 0;
	int               sent_bytes = 0;
	int               quiet_cycles = 0;
	int               stall_span = 0;
	stall_pattern_t   stall_mode = STALL_NONE;

	text_terminal_escape_engine_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_in(byte_in),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.op(op),
		.store_row(store_row),
		.store_col(store_col),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.char_code(char_code),
		.fg_colour(fg_colour),
		.bg_colour(bg_colour),
		.top_row(top_row),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= stall_pattern_t'($urandom_range(0, 3));
			stall_span <= int'($urandom_range(40, 300));
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
			STALL_NONE:     result_stall <= 1'b0;
			STALL_COIN:     result_stall <= 1'($urandom_range(0, 1));
			STALL_PERIODIC: result_stall <= stall_span[2];
			default:        result_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	always @(posedge clk) begin
		tte_pkg::result_t got;
		if (arst_n && result_valid && !result_stall) begin
			got = '{tte_pkg::op_t'(op), store_row, store_col, pixel_x, pixel_y, char_code,
				fg_colour, bg_colour, top_row, last};
			shadow.check_command(got);
		end
	end

	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (burst_left == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		end
		byte_valid <= 1'b1;
		byte_in <= b;
		do @(posedge clk); while (byte_stall);
		sent_bytes++;
		shadow.absorb_byte(b);
		burst_left--;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	task automatic hold_until_drained();
		byte_valid <= 1'b0;
		do @(posedge clk); while (shadow.pending_cmds.size() > 0);
	endtask

	// Escape bytes produce nothing, so the unit may still be busy when the queue empties.
	task automatic settle();
		hold_until_drained();
		repeat (8) @(posedge clk);
	endtask

	task automatic program_screen(input logic [tte_pkg::ORG_W-1:0] cols, rows, ox, oy);
		logic [tte_pkg::ORG_W-1:0]     vals[4];
		logic [tte_pkg::CFG_IDX_W-1:0] regs[4];
		vals = '{cols, rows, ox, oy};
		regs = '{tte_pkg::REG_COLUMNS, tte_pkg::REG_ROWS, tte_pkg::REG_ORIGIN_X,
			tte_pkg::REG_ORIGIN_Y};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			shadow.set_reg(regs[i], vals[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic send_sgr();
		int nparams;
		send_byte(tte_pkg::CH_ESC);
		nparams = $urandom_range(1, 4);
		for (int i = 0; i < nparams; i++) begin
			send_byte(i == 0 ? tte_pkg::CH_LBRACK : tte_pkg::CH_SEMI);
			case ($urandom_range(0, 5))
				0: ;
				1: send_text("0");
				2: send_text($sformatf("%0d", tte_pkg::SGR_FG_LOW + $urandom_range(0, 7)));
				3: send_text($sformatf("%0d", tte_pkg::SGR_BG_LOW + $urandom_range(0, 7)));
				4: send_text($sformatf("%0d", $urandom_range(0, 9999)));
				default: send_text($sformatf("%0d", $urandom_range(0, 99)));
			endcase
		end
		send_byte(tte_pkg::CH_M);
	endtask

	task automatic send_noise_escape();
		int         len;
		logic [7:0] b;
		send_byte(tte_pkg::CH_ESC);
		len = $urandom_range(1, 6);
		repeat (len) begin
			case ($urandom_range(0, 4))
				0: b = 8'(tte_pkg::CH_ZERO + $urandom_range(0, 9));
				1: b = tte_pkg::CH_LBRACK;
				2: b = tte_pkg::CH_SEMI;
				3: b = tte_pkg::CH_ESC;
				default: b = 8'($urandom_range(0, 255));
			endcase
			send_byte(b);
		end
		if (shadow.esc_active) send_byte(tte_pkg::CH_M);
	endtask

	task automatic random_stream(input int n);
		int         target;
		int         pick;
		logic [7:0] b;
		target = sent_bytes + n;
		while (sent_bytes < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(8'h20, 8'h7E)));
			end else if (pick < 57) begin
				case ($urandom_range(0, 3))
					0: send_byte(tte_pkg::CH_BS);
					1: send_byte(tte_pkg::CH_TAB);
					2: send_byte(tte_pkg::CH_LF);
					default: send_byte(tte_pkg::CH_CR);
				endcase
			end else if (pick < 71) begin
				send_sgr();
			end else if (pick < 79) begin
				send_noise_escape();
			end else if (pick < 99) begin
				b = 8'($urandom_range(0, 255));
				if (b == tte_pkg::CH_ESC) b = tte_pkg::CH_TAB;
				send_byte(b);
			end else begin
				hold_until_drained();
			end
		end
	endtask

	initial begin
		shadow = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry: controls, drawn control bytes and a mangled SGR sequence.
		send_text("A");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(tte_pkg::CH_CR);
		send_byte(tte_pkg::CH_BS);
		send_byte(tte_pkg::CH_TAB);
		send_byte(tte_pkg::CH_BS);
		send_byte(tte_pkg::CH_ESC);
		send_text("7[31x9;;44");
		send_byte(tte_pkg::CH_ESC);
		send_text("mB");
		send_byte(tte_pkg::CH_ESC);
		send_text("[300m");
		send_byte(tte_pkg::CH_LF);
		random_stream(150);
		settle();

		// Zero geometry clamps to a single cell at the far origin.
		program_screen(12'd0, 12'd0, 12'hFFF, 12'hFFF);
		send_text("a");
		send_byte(tte_pkg::CH_TAB);
		send_byte(tte_pkg::CH_LF);
		send_byte(tte_pkg::CH_BS);
		random_stream(60);
		settle();

		program_screen(12'd255, 12'd127, 12'd0, 12'd0);
		random_stream(150);
		settle();

		program_screen(12'd8, 12'd2, 12'($urandom_range(0, 4095)),
			12'($urandom_range(0, 4095)));
		random_stream(200);
		settle();

		program_screen(12'd128, 12'd64, 12'($urandom_range(0, 4095)),
			12'($urandom_range(0, 4095)));
		random_stream(150);
		settle();

		program_screen(12'd3, 12'd3, 12'($urandom_range(0, 4095)),
			12'($urandom_range(0, 4095)));
		random_stream(150);
		settle();

		repeat (3) begin
			program_screen(12'($urandom_range(1, 128)), 12'($urandom_range(1, 64)),
				12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
			random_stream(100);
			settle();
		end

		program_screen(12'hA50, 12'h7FF, 12'hFFF, 12'h000);
		random_stream(80);
		settle();

		shadow.close_out();
		if (shadow.mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
